@@ hw/rtl/sces_pkg.sv @@
// Shared types and constants for the small CPU execute step.
// Holds the word structs, the format and ALU select codes and the field layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sces_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_AW    = 3;
  localparam int unsigned DATA_W    = 16;

  // Instruction format field, bits 1:0
  typedef enum logic [1:0] {
    FMT_RR  = 2'd0,
    FMT_IMM = 2'd1,
    FMT_BR  = 2'd2,
    FMT_BAD = 2'd3
  } fmt_t;

  // ALU select, bits 4:2
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_AND = 3'd2,
    ALU_OR  = 3'd3,
    ALU_XOR = 3'd4,
    ALU_SHL = 3'd5,
    ALU_SHR = 3'd6,
    ALU_CMP = 3'd7
  } alu_sel_t;

  // Branch condition 3 never takes the branch
  localparam logic [1:0] COND_NEVER = 2'd3;

  // Compare results
  localparam logic [DATA_W-1:0] CMP_EQ = 16'd0;
  localparam logic [DATA_W-1:0] CMP_GT = 16'd1;
  localparam logic [DATA_W-1:0] CMP_LT = 16'd2;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] instruction;
    logic [15:0] prior_insn;
  } in_word_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        reg_written;
    logic [2:0]  dest_index;
    logic [15:0] dest_value;
    logic        bad_format;
  } out_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/small_cpu_execute_step_top.sv @@
// Execute step of a small 16-bit CPU: register file memory, ALU, branch resolve.
// Depends on sces_pkg.
//
//   channel | direction | ports                          | word
//   in      | input     | in_valid, in_stall, in_word    | pc, instruction, prior_insn
//   out     | output    | out_valid, out_stall, out_word | next_pc, reg_written, dest_index,
//           |           |                                | dest_value, bad_format
//
// One word per cycle sustained while out_stall does not hold the output; each word is
// registered in the execute stage and then in the output register.
// Accept cycle issues both register file reads (synchronous, registered read);
// the execute stage then runs the ALU, and writes back and loads the output register when it advances.
// A write from the previous word is forwarded to the operands of the next one.
// Reset clears the per-register valid bits so all registers read as zero; no sweep.
// out_stall holds the output register and, only if the execute stage is also full,
// stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module small_cpu_execute_step_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sces_pkg::in_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sces_pkg::out_word_t     out_word
);

  // Register file memory and per-entry valid bits
  logic [sces_pkg::DATA_W-1:0] mem [sces_pkg::NUM_REGS];
  logic [sces_pkg::NUM_REGS-1:0] reg_ok_r;

  // Execute stage
  logic                        s1_valid_r;
  sces_pkg::in_word_t          s1_word_r;
  logic [sces_pkg::DATA_W-1:0] rd_a_r, rd_b_r;
  logic                        rd_a_ok_r, rd_b_ok_r;

  // Last write-back, for forwarding
  logic                        fwd_en_r;
  logic [sces_pkg::REG_AW-1:0] fwd_addr_r;
  logic [sces_pkg::DATA_W-1:0] fwd_data_r;

  // Output register
  logic                out_valid_r;
  sces_pkg::out_word_t out_word_r;

  logic                        in_acc, s1_adv;
  logic [sces_pkg::REG_AW-1:0] ra_in, rb_in;
  sces_pkg::fmt_t              in_fmt;

  sces_pkg::fmt_t              s1_fmt;
  sces_pkg::alu_sel_t          s1_sel;
  logic [sces_pkg::REG_AW-1:0] s1_ra, s1_rb;
  logic [sces_pkg::DATA_W-1:0] op_a, op_b_reg, op_b, alu_res;
  logic [1:0]                  s1_cond;
  logic                        br_taken, s1_wr;
  sces_pkg::out_word_t         out_nxt;

  // Handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Read addresses: rx on port A; ry or the previous word's rx on port B
  assign in_fmt = sces_pkg::fmt_t'(in_word.instruction[1:0]);
  assign ra_in  = in_word.instruction[15:13];
  assign rb_in  = (in_fmt == sces_pkg::FMT_BR) ? in_word.prior_insn[15:13]
                                               : in_word.instruction[12:10];

  // Memory read and write-back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_a_r <= mem[ra_in];
      rd_b_r <= mem[rb_in];
    end
    if (s1_wr) begin
      mem[s1_ra] <= alu_res;
    end
  end

  // Valid bits, read valid flags and forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_ok_r  <= '0;
      fwd_en_r  <= 1'b0;
      rd_a_ok_r <= 1'b0;
      rd_b_ok_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_a_ok_r <= reg_ok_r[ra_in];
        rd_b_ok_r <= reg_ok_r[rb_in];
      end
      if (s1_wr) begin
        reg_ok_r[s1_ra] <= 1'b1;
        fwd_en_r        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fwd_addr_r <= s1_ra;
      fwd_data_r <= alu_res;
    end
  end

  // Execute stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_word;
    end
  end

  // Decode
  assign s1_fmt  = sces_pkg::fmt_t'(s1_word_r.instruction[1:0]);
  assign s1_sel  = sces_pkg::alu_sel_t'(s1_word_r.instruction[4:2]);
  assign s1_ra   = s1_word_r.instruction[15:13];
  assign s1_rb   = (s1_fmt == sces_pkg::FMT_BR) ? s1_word_r.prior_insn[15:13]
                                                : s1_word_r.instruction[12:10];
  assign s1_cond = s1_word_r.instruction[3:2];

  // Operands with forwarding; unwritten registers read as zero
  always_comb begin
    if (fwd_en_r && (fwd_addr_r == s1_ra)) begin
      op_a = fwd_data_r;
    end else begin
      op_a = rd_a_ok_r ? rd_a_r : '0;
    end
    if (fwd_en_r && (fwd_addr_r == s1_rb)) begin
      op_b_reg = fwd_data_r;
    end else begin
      op_b_reg = rd_b_ok_r ? rd_b_r : '0;
    end
    op_b = (s1_fmt == sces_pkg::FMT_IMM) ? {8'd0, s1_word_r.instruction[12:5]} : op_b_reg;
  end

  // ALU
  always_comb begin
    unique case (s1_sel)
      sces_pkg::ALU_ADD: alu_res = op_a + op_b;
      sces_pkg::ALU_SUB: alu_res = op_a - op_b;
      sces_pkg::ALU_AND: alu_res = op_a & op_b;
      sces_pkg::ALU_OR:  alu_res = op_a | op_b;
      sces_pkg::ALU_XOR: alu_res = op_a ^ op_b;
      sces_pkg::ALU_SHL: alu_res = (op_b[15:4] != 12'd0) ? '0 : (op_a << op_b[3:0]);
      sces_pkg::ALU_SHR: alu_res = (op_b[15:4] != 12'd0) ? '0 : (op_a >> op_b[3:0]);
      sces_pkg::ALU_CMP: begin
        if (op_a == op_b)     alu_res = sces_pkg::CMP_EQ;
        else if (op_a > op_b) alu_res = sces_pkg::CMP_GT;
        else                  alu_res = sces_pkg::CMP_LT;
      end
      default: alu_res = '0;
    endcase
  end

  // Branch compare against the register named by the previous word
  assign br_taken = (s1_cond != sces_pkg::COND_NEVER) && (op_b_reg == {14'd0, s1_cond});
  assign s1_wr    = s1_adv && ((s1_fmt == sces_pkg::FMT_RR) || (s1_fmt == sces_pkg::FMT_IMM));

  // Result word
  always_comb begin
    out_nxt             = '0;
    out_nxt.next_pc     = s1_word_r.pc + 16'd1;
    out_nxt.dest_index  = s1_ra;
    case (s1_fmt)
      sces_pkg::FMT_RR, sces_pkg::FMT_IMM: begin
        out_nxt.reg_written = 1'b1;
        out_nxt.dest_value  = alu_res;
      end
      sces_pkg::FMT_BR: begin
        if (br_taken) out_nxt.next_pc = {4'd0, s1_word_r.instruction[15:4]};
      end
      default: out_nxt.bad_format = 1'b1;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

@@ hw/rtl/sces_checker.sv @@
// Port-level checks for small_cpu_execute_step_top, attached with bind.
// Depends on sces_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sces_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire sces_pkg::in_word_t  in_word,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire sces_pkg::out_word_t out_word
);

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("out word changed while stalled");

  // Nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // Bad format or no write leaves value zero
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.reg_written |-> out_word.dest_value == 16'd0)
    else $error("dest_value nonzero without write");

  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_format |-> !out_word.reg_written)
    else $error("bad format word wrote a register");

endmodule

bind small_cpu_execute_step_top sces_checker u_sces_checker (.*);

`default_nettype wire
